[rtl/bba_pkg.sv]
package bba_pkg;

   // Sizing of the bitmap
   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int BLK_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = BLK_W + 1;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int WORD_IDX_W = $clog2(NUM_WORDS);

   // Field widths
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 2;

   // Reset values of the configuration
   localparam logic [BLK_W-1:0] FIRST_DATA_RESET   = '0;
   localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET  = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] INITIAL_FREE_RESET = CNT_W'(MAX_BLOCKS);

   // Commands
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_FIRST_DATA   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BLOCK_COUNT  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_INITIAL_FREE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_QUERY,
      S_FINISH
   } state_type;

endpackage

[rtl/bitmap_block_allocator_top.sv]
// First-fit block allocator over a one-bit-per-block usage bitmap held in a
// 128 x 32 synchronous RAM with a registered read. Allocate grants the lowest
// free block in [first_data_block, min(block_count, 4096)); free clears a bit
// in that range and counts the free counter up, saturating at block_count;
// query returns one bit. Every command gives exactly one response beat.
// Allocate scans n bitmap words (1 to 128), reading one per cycle through the
// single RAM read port; allocate refused at once (counter zero or empty range)
// and unknown commands skip the scan; free does a read-modify-write and query
// a read. One command is in flight at a time. A finished response waits in the
// output register while the next command is taken. The bitmap comes out of
// reset all free at once: each RAM row has a valid flop that reset clears, and
// a row never written reads as zero, so there is no clearing pass. Write
// configuration only while the block is idle; a write to initial_free also
// loads the free counter.
module bitmap_block_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bba_pkg::CMD_W-1:0]    req_command,
   input  logic [bba_pkg::BLK_W-1:0]    req_block_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bba_pkg::STAT_W-1:0]   rsp_status,
   output logic [bba_pkg::BLK_W-1:0]    rsp_allocated_block,
   output logic                         rsp_bit_value,
   output logic [bba_pkg::CNT_W-1:0]    rsp_free_count,
   input  logic                         csr_we,
   input  logic [bba_pkg::CSR_W-1:0]    csr_index,
   input  logic [bba_pkg::CNT_W-1:0]    csr_wdata
);
   import bba_pkg::*;

   // Lowest set bit of a word
   function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] vec);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) idx = BIT_IDX_W'(i);
      end
      return idx;
   endfunction

   state_type              state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [WORD_IDX_W-1:0]  cur_ff, cur_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [BLK_W-1:0]       grant_ff, grant_in;
   logic                   bitv_ff, bitv_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [BLK_W-1:0]       fdb_ff;
   logic [CNT_W-1:0]       bcount_ff;

   logic                   rsp_valid_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic [BLK_W-1:0]       rsp_grant_ff;
   logic                   rsp_bitv_ff;
   logic [CNT_W-1:0]       rsp_cnt_ff;

   // Bitmap RAM and row valid flops
   logic [WORD_BITS-1:0]   mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]   row_vld_ff;
   logic [WORD_BITS-1:0]   rdata_ff;
   logic                   rvld_ff;
   logic [WORD_IDX_W-1:0]  mem_raddr;
   logic                   mem_we;
   logic [WORD_IDX_W-1:0]  mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;

   logic                   req_fire;
   logic                   out_free;
   logic [CNT_W-1:0]       limit;
   logic [CNT_W-1:0]       limit_m1;
   logic [WORD_IDX_W-1:0]  last_word;
   logic [BIT_IDX_W-1:0]   last_bit;
   logic [WORD_IDX_W-1:0]  first_word;
   logic [WORD_BITS-1:0]   word;
   logic [WORD_BITS-1:0]   low_mask;
   logic [WORD_BITS-1:0]   high_mask;
   logic [WORD_BITS-1:0]   free_vec;
   logic [BIT_IDX_W-1:0]   hit_idx;
   logic                   range_empty;
   logic                   blk_in_range;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Scan limits
   assign limit       = (bcount_ff > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : bcount_ff;
   assign limit_m1    = limit - CNT_W'(1);
   assign last_word   = limit_m1[BLK_W-1:BIT_IDX_W];
   assign last_bit    = limit_m1[BIT_IDX_W-1:0];
   assign first_word  = fdb_ff[BLK_W-1:BIT_IDX_W];
   assign range_empty = (limit <= {1'b0, fdb_ff});

   // Word under examination; a row never written reads as free
   assign word = rvld_ff ? rdata_ff : '0;

   // Treat bits outside the allocatable range as used
   always_comb begin
      low_mask  = '0;
      high_mask = '0;
      if (cur_ff == first_word) begin
         low_mask = (WORD_BITS'(1) << fdb_ff[BIT_IDX_W-1:0]) - WORD_BITS'(1);
      end
      if (cur_ff == last_word) begin
         high_mask = ~({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - last_bit));
      end
   end

   assign free_vec     = ~(word | low_mask | high_mask);
   assign hit_idx      = lowest_set(free_vec);
   assign blk_in_range = (blk_ff >= fdb_ff) && ({1'b0, blk_ff} < limit);

   // Next state and datapath control
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      blk_in    = blk_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      bitv_in   = bitv_ff;
      cnt_in    = cnt_ff;
      mem_raddr = cur_ff + WORD_IDX_W'(1);
      mem_we    = 1'b0;
      mem_waddr = cur_ff;
      mem_wdata = word;

      case (state_ff)
         S_IDLE: begin
            if (csr_we && csr_index == CSR_INITIAL_FREE) begin
               cnt_in = csr_wdata;
            end
            if (req_fire) begin
               cmd_in    = req_command;
               blk_in    = req_block_number;
               grant_in  = '0;
               bitv_in   = 1'b0;
               status_in = STAT_INVALID;
               mem_raddr = req_block_number[BLK_W-1:BIT_IDX_W];
               case (req_command)
                  CMD_ALLOC: begin
                     if (cnt_ff == '0 || range_empty) begin
                        status_in = STAT_NOSPACE;
                        state_in  = S_FINISH;
                     end else begin
                        mem_raddr = first_word;
                        cur_in    = first_word;
                        state_in  = S_SCAN;
                     end
                  end
                  CMD_FREE:  state_in = S_FREE;
                  CMD_QUERY: state_in = S_QUERY;
                  default:   state_in = S_FINISH;
               endcase
            end
         end

         // Examine one word per cycle while the next one is read
         S_SCAN: begin
            if (free_vec != '0) begin
               mem_we    = 1'b1;
               mem_wdata = word | (WORD_BITS'(1) << hit_idx);
               cnt_in    = cnt_ff - CNT_W'(1);
               grant_in  = {cur_ff, hit_idx};
               status_in = STAT_OK;
               state_in  = S_FINISH;
            end else if (cur_ff == last_word) begin
               status_in = STAT_NOSPACE;
               state_in  = S_FINISH;
            end else begin
               cur_in = cur_ff + WORD_IDX_W'(1);
            end
         end

         // Clear the bit and count up, saturating
         S_FREE: begin
            if (blk_in_range) begin
               mem_we    = 1'b1;
               mem_waddr = blk_ff[BLK_W-1:BIT_IDX_W];
               mem_wdata = word & ~(WORD_BITS'(1) << blk_ff[BIT_IDX_W-1:0]);
               if (cnt_ff < bcount_ff && cnt_ff != {CNT_W{1'b1}}) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               status_in = STAT_OK;
            end
            state_in = S_FINISH;
         end

         // Every 12-bit block number lies below the bitmap size
         S_QUERY: begin
            bitv_in   = word[blk_ff[BIT_IDX_W-1:0]];
            status_in = STAT_OK;
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= INITIAL_FREE_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Command payload and pending result
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      blk_ff    <= blk_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
      bitv_ff   <= bitv_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fdb_ff    <= FIRST_DATA_RESET;
         bcount_ff <= BLOCK_COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_FIRST_DATA)  fdb_ff    <= csr_wdata[BLK_W-1:0];
         if (csr_index == CSR_BLOCK_COUNT) bcount_ff <= csr_wdata;
      end
   end

   // Bitmap RAM: registered read, one write port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[mem_raddr];
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   // Row valid flops: clear at reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rvld_ff    <= 1'b0;
      end else begin
         rvld_ff <= row_vld_ff[mem_raddr];
         if (mem_we) row_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // Output register: load the result beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_grant_ff  <= grant_ff;
         rsp_bitv_ff   <= bitv_ff;
         rsp_cnt_ff    <= cnt_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_block = rsp_grant_ff;
   assign rsp_bit_value       = rsp_bitv_ff;
   assign rsp_free_count      = rsp_cnt_ff;

   // Checks
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_SCAN || state_ff == S_FREE))
      else $error("bitmap write outside scan or free");

   a_grant_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_we) |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("grant without counter decrement");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (cur_ff <= last_word && cur_ff >= first_word))
      else $error("scan pointer out of range");

   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cmd_ff == CMD_ALLOC && status_ff == STAT_OK)
      |-> (grant_ff >= fdb_ff && {1'b0, grant_ff} < limit))
      else $error("granted block outside range");

endmodule
